### hw/rtl/f2d_pkg.sv
// Shared types and constants of the binary32 to decimal text converter.
// No dependencies; compiled first.
package f2d_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PRECISION   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_STYLE = 4'd1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam int DEFAULT_DIGITS = 7;
	localparam int SCALE_LIMIT    = 64;

	localparam int SIG_W = 53;
	localparam int EXP_W = 12;

	typedef logic [SIG_W-1:0] sig_t;
	typedef logic signed [EXP_W-1:0] exp_t;

	// Binary64 magnitude: value is sig * 2^(ex-52), sig normalised unless zero.
	typedef struct packed {
		logic zero;
		exp_t ex;
		sig_t sig;
	} dbl_t;

endpackage

### hw/rtl/f2d_if.sv
// Request channels of the converter: sample input, text output and register writes.
// Depends on f2d_pkg for the register port widths.
interface f2d_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;
	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

interface f2d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;
	logic       bad_value;
	modport source (output valid, output text_char, output last_char, output bad_value,
		input ready);
	modport sink   (input valid, input text_char, input last_char, input bad_value,
		output ready);
endinterface

interface f2d_cfg_if import f2d_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/float_to_decimal_ascii_unit.sv
// Binary32 to decimal ASCII converter. One request is taken only while idle; an infinity or
// NaN gives a single error character. A divide-by-ten is a compare, eight steps of the shared
// radix-256 divider and a rounding step; a multiply-by-ten is combinational. The time for a
// finite value is set by the scaling and rounding divisions and the digit count; characters
// wait in the output register until the sink takes them. arst_n clears the sequencer, the
// output valid and the configuration registers; working registers are loaded by each request.
module float_to_decimal_ascii_unit import f2d_pkg::*; #(
	parameter int MAX_DIGITS = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	f2d_in_if.sink           sample,
	f2d_out_if.source        text,
	f2d_cfg_if.sink          cfg
);

	typedef enum logic [4:0] {
		S_IDLE, S_BAD, S_SIGN, S_NORM, S_UP, S_DN, S_DIV, S_DT, S_RU, S_ADD, S_FIX,
		S_PLAN, S_LZ0, S_LZP, S_LZZ, S_PEEL, S_DIG, S_PT, S_MUL, S_EXPE, S_EXPM,
		S_EXPT, S_EXPU
	} state_t;

	localparam dbl_t ONE = '{zero: 1'b0, ex: '0, sig: {1'b1, {(SIG_W-1){1'b0}}}};

	state_t             state_q;
	logic [4:0]         prec_q;
	logic               fixed_q;
	dbl_t               w_q, ru_q;
	logic signed [7:0]  dexp_q, dt_q;
	logic [6:0]         idx_q, cnt_q, em_q;
	logic [3:0]         k_q;
	logic               ret_mul_q, has_exp_q;
	logic               ov_q, ol_q, ob_q;
	logic [7:0]         oc_q;
	logic [63:0]        dv_num_q, dv_quo_q;
	logic [3:0]         dv_rem_q, dv_cnt_q;
	logic               dv_ru_q;
	exp_t               dv_e_q;

	function automatic dbl_t rne(input sig_t m, input logic g, input logic s, input exp_t e);
		logic [SIG_W:0] sum;
		dbl_t r;
		sum = {1'b0, m} + {{SIG_W{1'b0}}, g & (s | m[0])};
		r.zero = 1'b0;
		if (sum[SIG_W]) begin
			r.sig = sum[SIG_W:1];
			r.ex  = e + exp_t'(1);
		end else begin
			r.sig = sum[SIG_W-1:0];
			r.ex  = e;
		end
		return r;
	endfunction

	function automatic dbl_t mul10(input dbl_t a);
		logic [56:0] p;
		p = {1'b0, a.sig, 3'b000} + {3'b000, a.sig, 1'b0};
		if (a.zero)
			return a;
		else if (p[56])
			return rne(p[56:4], p[3], |p[2:0], a.ex + exp_t'(4));
		else
			return rne(p[55:3], p[2], |p[1:0], a.ex + exp_t'(3));
	endfunction

	function automatic dbl_t add_half(input dbl_t a, input dbl_t b);
		dbl_t h, big, sml;
		exp_t d;
		logic [55:0]  sx;
		logic [111:0] t;
		logic [56:0]  s;
		h    = b;
		h.ex = b.ex - exp_t'(1);
		if (a.ex >= h.ex) begin
			big = a;
			sml = h;
		end else begin
			big = h;
			sml = a;
		end
		d = big.ex - sml.ex;
		t = {sml.sig, 3'b000, 56'd0} >> d[5:0];
		if (d >= exp_t'(56))
			sx = 56'd1;
		else
			sx = t[111:56] | {55'd0, |t[55:0]};
		s = {1'b0, big.sig, 3'b000} + {1'b0, sx};
		if (a.zero)
			return h;
		else if (s[56])
			return rne(s[56:4], s[3], |s[2:0], big.ex + exp_t'(1));
		else
			return rne(s[55:3], s[2], |s[1:0], big.ex);
	endfunction

	function automatic logic ge10(input dbl_t a);
		return !a.zero && (a.ex > exp_t'(3) || (a.ex == exp_t'(3) && a.sig[52:49] >= 4'd10));
	endfunction

	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [3:0] r;
		r = '0;
		for (int t = 1; t < 10; t++)
			if (v >= 7'(10 * t))
				r = 4'(t);
		return r;
	endfunction

	// Radix-256 step of the divide-by-ten: eight restoring steps on a remainder below ten.
	logic [3:0] dv_rem_d;
	logic [7:0] dv_qb;
	always_comb begin
		logic [4:0] t;
		dv_rem_d = dv_rem_q;
		dv_qb    = '0;
		for (int j = 0; j < 8; j++) begin
			t = {dv_rem_d, dv_num_q[63-j]};
			if (t >= 5'd10) begin
				dv_qb[7-j] = 1'b1;
				dv_rem_d   = 4'(t - 5'd10);
			end else begin
				dv_rem_d = t[3:0];
			end
		end
	end

	dbl_t dv_res;
	always_comb begin
		if (dv_quo_q[55])
			dv_res = rne(dv_quo_q[55:3], dv_quo_q[2], (|dv_quo_q[1:0]) | (dv_rem_q != 4'd0),
				dv_e_q - exp_t'(3));
		else
			dv_res = rne(dv_quo_q[54:2], dv_quo_q[1], dv_quo_q[0] | (dv_rem_q != 4'd0),
				dv_e_q - exp_t'(4));
	end

	// Integer and fraction parts of the working value while digits are peeled.
	logic [3:0] pk;
	sig_t       pf;
	always_comb begin
		pk = '0;
		pf = w_q.sig;
		if (!w_q.zero && w_q.ex >= exp_t'(0)) begin
			unique case (w_q.ex[1:0])
				2'd0: begin pk = {3'b000, w_q.sig[52]};  pf = w_q.sig & {1'b0, {52{1'b1}}}; end
				2'd1: begin pk = {2'b00, w_q.sig[52:51]}; pf = w_q.sig & {2'b0, {51{1'b1}}}; end
				2'd2: begin pk = {1'b0, w_q.sig[52:50]}; pf = w_q.sig & {3'b0, {50{1'b1}}}; end
				2'd3: begin pk = w_q.sig[52:49];         pf = w_q.sig & {4'b0, {49{1'b1}}}; end
				default: ;
			endcase
		end
	end

	// Widening of the request value.
	logic [7:0]  in_ef;
	logic [22:0] in_mf;
	logic        in_zero, in_bad;
	logic [5:0]  dt_base;
	assign in_ef   = sample.value_bits[30:23];
	assign in_mf   = sample.value_bits[22:0];
	assign in_zero = (in_ef == 8'd0) && (in_mf == 23'd0);
	assign in_bad  = (in_ef == 8'hFF);
	always_comb begin
		dt_base = (prec_q == 5'd0) ? 6'(DEFAULT_DIGITS) : {1'b0, prec_q} + 6'd1;
		if (dt_base > 6'(MAX_DIGITS))
			dt_base = 6'(MAX_DIGITS);
	end

	logic signed [7:0] idx_s;
	logic              last_dig, point_here;
	logic signed [8:0] lim9, nz9;
	logic [3:0]        tens;
	assign idx_s      = {1'b0, idx_q};
	assign last_dig   = (idx_s + 8'sd1) == dt_q;
	assign point_here = fixed_q ? (idx_s == dexp_q) : (idx_q == 7'd0);
	assign lim9       = (dt_q < 8'sd0) ? (9'(dexp_q) - 9'(dt_q)) : 9'(dexp_q);
	assign nz9        = -lim9 - 9'sd1;
	assign tens       = tens_of(em_q);

	// Character selection of the emitting states.
	logic       out_free, emit_go, emit_last, emit_bad;
	logic [7:0] emit_ch;
	assign out_free = !ov_q || text.ready;
	always_comb begin
		emit_go   = 1'b0;
		emit_ch   = '0;
		emit_last = 1'b0;
		emit_bad  = 1'b0;
		unique case (state_q)
			S_BAD:  begin emit_go = 1'b1; emit_last = 1'b1; emit_bad = 1'b1; end
			S_SIGN: begin emit_go = 1'b1; emit_ch = CH_MINUS; end
			S_LZ0:  begin emit_go = 1'b1; emit_ch = CH_ZERO; end
			S_LZP:  begin
				emit_go   = 1'b1;
				emit_ch   = CH_POINT;
				emit_last = (cnt_q == 7'd0) && (dt_q <= 8'sd0);
			end
			S_LZZ:  begin
				emit_go   = 1'b1;
				emit_ch   = CH_ZERO;
				emit_last = (cnt_q == 7'd1) && (dt_q <= 8'sd0);
			end
			S_DIG:  begin
				emit_go   = 1'b1;
				emit_ch   = CH_ZERO + {4'd0, k_q};
				emit_last = last_dig && !point_here && !has_exp_q;
			end
			S_PT:   begin
				emit_go   = 1'b1;
				emit_ch   = CH_POINT;
				emit_last = last_dig && !has_exp_q;
			end
			S_EXPE: begin emit_go = 1'b1; emit_ch = CH_E; end
			S_EXPM: begin emit_go = 1'b1; emit_ch = CH_MINUS; end
			S_EXPT: begin emit_go = (em_q >= 7'd10); emit_ch = CH_ZERO + {4'd0, tens}; end
			S_EXPU: begin
				emit_go   = 1'b1;
				emit_ch   = CH_ZERO + 8'(em_q - ({tens, 3'b000} + {2'b00, tens, 1'b0}));
				emit_last = 1'b1;
			end
			default: ;
		endcase
		emit_go = emit_go && out_free;
	end

	assign sample.ready   = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign text.valid     = ov_q;
	assign text.text_char = oc_q;
	assign text.last_char = ol_q;
	assign text.bad_value = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prec_q  <= '0;
			fixed_q <= 1'b0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			dv_cnt_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_PRECISION)
					prec_q <= cfg.data[4:0];
				else if (cfg.index == REG_FIXED_STYLE)
					fixed_q <= cfg.data[0];
			end
			if (text.valid && text.ready)
				ov_q <= 1'b0;
			if (emit_go) begin
				ov_q <= 1'b1;
				oc_q <= emit_ch;
				ol_q <= emit_last;
				ob_q <= emit_bad;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						w_q.zero  <= in_zero;
						w_q.sig   <= {(in_ef != 8'd0), in_mf, 29'd0};
						w_q.ex    <= (in_ef == 8'd0) ? -exp_t'(126) : exp_t'(in_ef) - exp_t'(127);
						dexp_q    <= '0;
						dt_q      <= 8'(dt_base);
						ret_mul_q <= 1'b0;
						if (in_bad)
							state_q <= S_BAD;
						else if (sample.value_bits[31] && !in_zero)
							state_q <= S_SIGN;
						else
							state_q <= S_NORM;
					end
				end
				S_BAD:  if (out_free) state_q <= S_IDLE;
				S_SIGN: if (out_free) state_q <= S_NORM;
				S_NORM: begin
					if (w_q.zero || w_q.sig[SIG_W-1]) begin
						cnt_q   <= '0;
						state_q <= ret_mul_q ? S_MUL : S_UP;
					end else if (w_q.sig[52:45] == 8'd0) begin
						w_q.sig <= {w_q.sig[44:0], 8'd0};
						w_q.ex  <= w_q.ex - exp_t'(8);
					end else begin
						w_q.sig <= {w_q.sig[51:0], 1'b0};
						w_q.ex  <= w_q.ex - exp_t'(1);
					end
				end
				S_UP: begin
					if (!w_q.zero && w_q.ex < exp_t'(0) && cnt_q < 7'(SCALE_LIMIT)) begin
						w_q    <= mul10(w_q);
						dexp_q <= dexp_q - 8'sd1;
						cnt_q  <= cnt_q + 7'd1;
					end else begin
						cnt_q   <= '0;
						state_q <= S_DN;
					end
				end
				S_DN: begin
					if (ge10(w_q) && cnt_q < 7'(SCALE_LIMIT)) begin
						dv_num_q <= {5'd0, w_q.sig, 6'd0};
						dv_quo_q <= '0;
						dv_rem_q <= '0;
						dv_cnt_q <= 4'd8;
						dv_e_q   <= w_q.ex;
						dv_ru_q  <= 1'b0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_DT;
					end
				end
				S_DIV: begin
					if (dv_cnt_q != 4'd0) begin
						dv_num_q <= {dv_num_q[55:0], 8'd0};
						dv_quo_q <= {dv_quo_q[55:0], dv_qb};
						dv_rem_q <= dv_rem_d;
						dv_cnt_q <= dv_cnt_q - 4'd1;
					end else if (dv_ru_q) begin
						ru_q    <= dv_res;
						state_q <= S_RU;
					end else begin
						w_q     <= dv_res;
						dexp_q  <= dexp_q + 8'sd1;
						cnt_q   <= cnt_q + 7'd1;
						state_q <= S_DN;
					end
				end
				S_DT: begin
					if (fixed_q)
						dt_q <= dt_q + dexp_q;
					ru_q    <= ONE;
					cnt_q   <= 7'd1;
					state_q <= S_RU;
				end
				S_RU: begin
					if ($signed({1'b0, cnt_q}) < dt_q) begin
						dv_num_q <= {5'd0, ru_q.sig, 6'd0};
						dv_quo_q <= '0;
						dv_rem_q <= '0;
						dv_cnt_q <= 4'd8;
						dv_e_q   <= ru_q.ex;
						dv_ru_q  <= 1'b1;
						cnt_q    <= cnt_q + 7'd1;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					w_q     <= add_half(w_q, ru_q);
					state_q <= S_FIX;
				end
				S_FIX: begin
					// A round-up that reaches ten restarts the digits at one.
					if (ge10(w_q)) begin
						w_q    <= ONE;
						dexp_q <= dexp_q + 8'sd1;
					end
					state_q <= S_PLAN;
				end
				S_PLAN: begin
					has_exp_q <= !fixed_q && (dexp_q != 8'sd0);
					em_q      <= (dexp_q < 8'sd0) ? 7'(-dexp_q) : 7'(dexp_q);
					idx_q     <= '0;
					cnt_q     <= (nz9 < 9'sd0) ? 7'd0 : 7'(nz9);
					state_q   <= (fixed_q && dexp_q < 8'sd0) ? S_LZ0 : S_PEEL;
				end
				S_LZ0: if (out_free) state_q <= S_LZP;
				S_LZP: if (out_free) state_q <= (cnt_q == 7'd0) ? S_PEEL : S_LZZ;
				S_LZZ: begin
					if (out_free) begin
						cnt_q <= cnt_q - 7'd1;
						if (cnt_q == 7'd1)
							state_q <= S_PEEL;
					end
				end
				S_PEEL: begin
					if (idx_s < dt_q) begin
						k_q       <= pk;
						w_q.sig   <= pf;
						w_q.zero  <= w_q.zero || (pf == '0);
						ret_mul_q <= 1'b1;
						state_q   <= S_DIG;
					end else begin
						state_q <= has_exp_q ? S_EXPE : S_IDLE;
					end
				end
				S_DIG: if (out_free) state_q <= point_here ? S_PT : S_NORM;
				S_PT:  if (out_free) state_q <= S_NORM;
				S_MUL: begin
					w_q     <= mul10(w_q);
					idx_q   <= idx_q + 7'd1;
					state_q <= S_PEEL;
				end
				S_EXPE: if (out_free) state_q <= (dexp_q < 8'sd0) ? S_EXPM : S_EXPT;
				S_EXPM: if (out_free) state_q <= S_EXPT;
				S_EXPT: if (out_free || em_q < 7'd10) state_q <= S_EXPU;
				S_EXPU: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a request");

	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.bad_value |-> text.last_char && text.text_char == 8'd0)
		else $error("error result is not a single empty character");

	a_div_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && dv_cnt_q == 4'd0 |-> dv_quo_q[55] || dv_quo_q[54])
		else $error("divide-by-ten quotient lost its leading bit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIG |-> k_q <= 4'd9)
		else $error("peeled digit above nine");

endmodule
